// ===== src/depq_pkg.sv =====
// ============================================================================
// depq_pkg: shared types and constants
// Widths, opcodes and status codes for the double-ended priority queue.
// ============================================================================
package depq_pkg;
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 32;
    localparam int PRIO_W   = 32;
    localparam int ENTRY_W  = ID_W + PRIO_W;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_POP_MAX = 2'd1;
    localparam logic [1:0] OP_POP_MIN = 2'd2;

    localparam logic [1:0] ST_SERVED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ENTRY_W-1:0] t_entry;

    // memory port bundle from the sequencer to the store
    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
    } t_mem_req;
endpackage

// ===== src/depq_store.sv =====
// ============================================================================
// depq_store: entry memory
// One write port and one registered read port; read data appears the cycle after the read is issued.
// ============================================================================
module depq_store
    import depq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);
    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/double_ended_priority_queue_unit.sv =====
// ============================================================================
// double_ended_priority_queue_unit: bounded double-ended priority queue
// Stores (client id, priority) pairs in one memory; pops scan for the extreme.
// ============================================================================
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+-------------------
//  command  | i_opcode, i_client_id, i_priority_req      | start & !busy
//  result   | o_status, o_served_id                      | o_strobe, 1 cycle
//
// Insert: memory write, no result unless full (result next cycle).
// Pop: scan of the live entries through the single read port, one read per
// cycle; then the last entry moves into the hole.
// Reset clears the count and control; memory contents stay undefined.
// Results cannot be stalled; busy stays high until the result is shown.
// ============================================================================
module double_ended_priority_queue_unit
    import depq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_client_id,
    input  logic [31:0] i_priority_req,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_served_id
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;   // issue reads, compare returned data
    localparam logic [2:0] S_LAST = 3'd2;   // read of last entry returns
    localparam logic [2:0] S_MOVE = 3'd3;   // write last entry into hole

    logic [2:0]  r_state, n_state;
    t_cnt        r_count, n_count;
    t_addr       r_rd_idx, n_rd_idx;      // next address to read
    t_cnt        r_cmp_idx, n_cmp_idx;    // index of data now on the read port
    logic        r_max, n_max;
    t_addr       r_best_idx, n_best_idx;
    t_entry      r_best, n_best;
    logic        r_strobe, n_strobe;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_id, n_id;

    t_mem_req    mem_req;
    t_entry      rd_data;

    depq_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    logic accept;
    logic better;
    t_cnt last;
    assign accept = start && !busy;
    assign last   = r_count - t_cnt'(1);
    assign better = r_max ? (rd_data[ENTRY_W-1:ID_W] > r_best[ENTRY_W-1:ID_W])
                          : (rd_data[ENTRY_W-1:ID_W] < r_best[ENTRY_W-1:ID_W]);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_cmp_idx  = r_cmp_idx;
        n_max      = r_max;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_id       = r_id;
        mem_req    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_INSERT) begin
                        if (r_count == t_cnt'(CAPACITY)) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                            n_id     = '0;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_count[ADDR_W-1:0];
                            mem_req.wr_data = {i_priority_req, i_client_id};
                            n_count         = r_count + t_cnt'(1);
                        end
                    end else if (i_opcode == OP_POP_MAX || i_opcode == OP_POP_MIN) begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                            n_id     = '0;
                        end else begin
                            n_max           = (i_opcode == OP_POP_MAX);
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            n_rd_idx        = t_addr'(1);
                            n_cmp_idx       = '0;
                            n_state         = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // data for r_cmp_idx is on rd_data
                if (r_cmp_idx == '0 || better) begin
                    n_best     = rd_data;
                    n_best_idx = r_cmp_idx[ADDR_W-1:0];
                end
                n_cmp_idx = r_cmp_idx + t_cnt'(1);
                if (r_cmp_idx + t_cnt'(1) < r_count) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_rd_idx;
                    n_rd_idx        = r_rd_idx + t_addr'(1);
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = last[ADDR_W-1:0];
                    n_state         = S_LAST;
                end
            end
            S_LAST: begin
                n_strobe = 1'b1;
                n_status = ST_SERVED;
                n_id     = r_best[ID_W-1:0];
                n_count  = last;
                n_state  = S_MOVE;
            end
            S_MOVE: begin
                // hole refill; r_count already decremented
                if (r_best_idx != r_count[ADDR_W-1:0]) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_best_idx;
                    mem_req.wr_data = rd_data;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_max      <= n_max;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_status   <= n_status;
        r_id       <= n_id;
    end

    // busy also covers the cycle the result is shown
    assign busy        = (r_state != S_IDLE) || r_strobe;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_served_id = r_id;
endmodule
